/* hdl/tosa_pkg.sv */
// ----------------------------------------------------------------------------
// tosa_pkg
// Shared sizes, codes and the exp table of the tiled attention block.
// ----------------------------------------------------------------------------
package tosa_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_DIM  = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_DIM);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_DIM;

  localparam int ELEM_W  = 16;
  localparam int CNT_W   = 7;
  localparam int SCALE_W = 16;
  localparam int DOT_W   = 38;
  localparam int SCORE_W = 32;
  localparam int ACC_W   = 32;
  localparam int TOT_W   = 32;
  localparam int EXP_W   = 17;
  localparam int EXPX_W  = SCORE_W + 1;
  localparam int FRAC_W  = 12;
  localparam int NUM_W   = ACC_W + FRAC_W;

  localparam logic [2:0] OP_LOAD_Q  = 3'd0;
  localparam logic [2:0] OP_LOAD_K  = 3'd1;
  localparam logic [2:0] OP_LOAD_V  = 3'd2;
  localparam logic [2:0] OP_COMPUTE = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [1:0] CFG_SEQ_LEN     = 2'd0;
  localparam logic [1:0] CFG_HEAD_DIM    = 2'd1;
  localparam logic [1:0] CFG_BLOCK_LEN   = 2'd2;
  localparam logic [1:0] CFG_SCORE_SCALE = 2'd3;

  typedef struct packed {
    logic en;
    logic first;
  } mac_ctl_t;

  // 2^(-k/16) in Q1.16
  function automatic logic [EXP_W-1:0] pow2_tab(input logic [4:0] k);
    logic [EXP_W-1:0] t;
    unique case (k)
      5'd0:  t = 17'd65536;
      5'd1:  t = 17'd62757;
      5'd2:  t = 17'd60097;
      5'd3:  t = 17'd57549;
      5'd4:  t = 17'd55109;
      5'd5:  t = 17'd52773;
      5'd6:  t = 17'd50535;
      5'd7:  t = 17'd48393;
      5'd8:  t = 17'd46341;
      5'd9:  t = 17'd44376;
      5'd10: t = 17'd42495;
      5'd11: t = 17'd40693;
      5'd12: t = 17'd38968;
      5'd13: t = 17'd37316;
      5'd14: t = 17'd35734;
      5'd15: t = 17'd34219;
      default: t = 17'd32768;
    endcase
    return t;
  endfunction

endpackage

/* hdl/tosa_ram.sv */
// ----------------------------------------------------------------------------
// tosa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tosa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tosa_score.sv */
// ----------------------------------------------------------------------------
// tosa_score
// Dot product accumulator and Q0.16 score scaling, two stages after the MAC.
// ----------------------------------------------------------------------------
module tosa_score import tosa_pkg::*; (
  input  logic                      clk,
  input  mac_ctl_t                  mac,
  input  logic signed [ELEM_W-1:0]  q,
  input  logic signed [ELEM_W-1:0]  k,
  input  logic [SCALE_W-1:0]        scale,
  output logic signed [SCORE_W-1:0] score
);

  localparam int SPLIT = 20;
  localparam int HI_W  = DOT_W - SPLIT;
  localparam int SH    = 28;

  logic signed [2*ELEM_W-1:0]     prod;
  logic signed [DOT_W-1:0]        dot_r;
  logic [SPLIT+SCALE_W-1:0]       lo_r;
  logic signed [HI_W+SCALE_W:0]   hi_r;
  logic signed [DOT_W+SCALE_W:0]  full;
  logic signed [SCORE_W-1:0]      score_r;

  assign prod = q * k;
  assign full = $signed({hi_r, {SPLIT{1'b0}}})
              + $signed({{(DOT_W+1-SPLIT){1'b0}}, lo_r});

  always_ff @(posedge clk) begin
    if (mac.en) begin
      dot_r <= mac.first ? DOT_W'(prod) : dot_r + DOT_W'(prod);
    end
    lo_r    <= dot_r[SPLIT-1:0] * scale;
    hi_r    <= $signed(dot_r[DOT_W-1:SPLIT]) * $signed({1'b0, scale});
    score_r <= SCORE_W'(full >>> SH);
  end

  assign score = score_r;

endmodule

/* hdl/tosa_exp.sv */
// ----------------------------------------------------------------------------
// tosa_exp
// exp(-x) for x >= 0 in Q.12, Q1.16 result, two-stage table interpolation.
// ----------------------------------------------------------------------------
module tosa_exp import tosa_pkg::*; (
  input  logic              clk,
  input  logic [EXPX_W-1:0] x,
  output logic [EXP_W-1:0]  e
);

  localparam logic [14:0] LOG2E = 15'd23637;
  localparam int YF_W = EXPX_W + 15;
  localparam int Y_W  = YF_W - 14;
  localparam int IP_W = Y_W - FRAC_W;

  logic [YF_W-1:0]       y_full;
  logic [Y_W-1:0]        y;
  logic [IP_W-1:0]       ip_w;
  logic                  zero_r;
  logic [4:0]            ip_r;
  logic [FRAC_W-1:0]     f_r;
  logic [EXP_W-1:0]      t0, t1, diff, t;
  logic [EXP_W+7:0]      interp;
  logic [EXP_W-1:0]      e_r;

  assign y_full = x * LOG2E;
  assign y      = y_full[YF_W-1:14];
  assign ip_w   = y[Y_W-1:FRAC_W];

  assign t0     = pow2_tab({1'b0, f_r[11:8]});
  assign t1     = pow2_tab({1'b0, f_r[11:8]} + 5'd1);
  assign diff   = t0 - t1;
  assign interp = diff * f_r[7:0];
  assign t      = t0 - interp[EXP_W+7:8];

  always_ff @(posedge clk) begin
    zero_r <= ip_w > IP_W'(16);
    ip_r   <= ip_w[4:0];
    f_r    <= y[FRAC_W-1:0];
    e_r    <= zero_r ? '0 : (t >> ip_r);
  end

  assign e = e_r;

endmodule

/* hdl/tosa_div.sv */
// ----------------------------------------------------------------------------
// tosa_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tosa_div import tosa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [TOT_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [TOT_W:0]    rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [TOT_W:0]    rem_sh;
  logic              fit;

  assign rem_sh = {rem_r[TOT_W-1:0], quo_r[NUM_W-1]};
  assign fit    = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(NUM_W - 1);
        rem_r  <= '0;
        quo_r  <= num;
      end else if (busy_r) begin
        rem_r <= fit ? rem_sh - {1'b0, den} : rem_sh;
        quo_r <= {quo_r[NUM_W-2:0], fit};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* hdl/tiled_online_softmax_attention.sv */
// ----------------------------------------------------------------------------
// tiled_online_softmax_attention
// Q4.12 attention for one slice with blockwise online softmax over key tiles.
//
//   channel  dir  handshake          word
//   in_      in   in_valid/in_stall  opcode, row, col, value
//   out_     out  out_valid/out_stall value, row, col of one output element
//   cfg_     in   cfg_valid/cfg_ready register index, data
//
// A load is written to its store when accepted; a read goes through the
// accumulator read register into the output register. A compute holds the
// input stalled: per key tile and row it finds the new max, rescales the row
// and adds weighted values; a final pass divides (44-step serial divider).
// The compute loop is set by the single read port of each store.
// Reset is synchronous; no clearing pass, the output region is tracked.
// A read is taken only while the output register is free.
// ----------------------------------------------------------------------------
module tiled_online_softmax_attention import tosa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               in_opcode,
  input  logic [ROW_W-1:0]         in_row,
  input  logic [COL_W-1:0]         in_col,
  input  logic signed [ELEM_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] out_value,
  output logic [ROW_W-1:0]         out_row,
  output logic [COL_W-1:0]         out_col,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_INIT, S_BLK, S_ROW0, S_ROW1, S_DOT, S_DOTW, S_SC1, S_SC2,
    S_SCORE, S_X1, S_X2, S_X3, S_TOT, S_RS_Z, S_RS_RD, S_RS_WR, S_AD_RD,
    S_AD_WR, S_ROWEND, S_FN_ROW, S_FN_ROW1, S_FN_RD, S_FN_ST, S_FN_WT
  } state_t;

  localparam int WIDE_W = ACC_W + EXP_W + 1;
  localparam logic [NUM_W-1:0] Q_MAX     = NUM_W'(32767);
  localparam logic [NUM_W-1:0] Q_MIN_MAG = NUM_W'(32768);

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi, lo;
    hi = WIDE_W'({1'b0, {(ACC_W-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) return {1'b0, {(ACC_W-1){1'b1}}};
    if (v < lo) return {1'b1, {(ACC_W-1){1'b0}}};
    return v[ACC_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cfg(input logic [CNT_W-1:0] v, input int hi);
    if (v == '0) return CNT_W'(1);
    if (v > CNT_W'(hi)) return CNT_W'(hi);
    return v;
  endfunction

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] seq_len_r, seq_len_nxt, head_dim_r, head_dim_nxt;
  logic [CNT_W-1:0] block_len_r, block_len_nxt;
  logic [SCALE_W-1:0] score_scale_r, score_scale_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, d_r, d_nxt, bl_r, bl_nxt, bs_r, bs_nxt, be_r, be_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, c_r, c_nxt;
  logic pass_r, pass_nxt, prev_r, prev_nxt, have_r, have_nxt, done_r, done_nxt;
  logic signed [SCORE_W-1:0] mp_r, mp_nxt, mn_r, mn_nxt;
  logic [TOT_W-1:0] tot_r, tot_nxt, den_r, den_nxt;
  logic [EXP_W-1:0] r_r, r_nxt, e_r, e_nxt;
  logic neg_r, neg_nxt;
  logic [ROW_W-1:0] rd_row_r, rd_row_nxt, out_row_r, out_row_nxt;
  logic [COL_W-1:0] rd_col_r, rd_col_nxt, out_col_r, out_col_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [ELEM_W-1:0] out_value_r, out_value_nxt;
  mac_ctl_t mac_r, mac_nxt;

  logic accept;
  logic q_we, k_we, v_we, acc_we, rm_we;
  logic [ADDR_W-1:0] in_addr, qi_addr, kj_addr, acc_raddr;
  logic signed [ACC_W-1:0] acc_wdata;
  logic signed [ELEM_W-1:0] q_rd, k_rd, v_rd;
  logic signed [ACC_W-1:0] acc_rd;
  logic [SCORE_W-1:0] rmax_rd;
  logic [TOT_W-1:0] rtot_rd;
  logic signed [SCORE_W-1:0] score;
  logic [EXP_W-1:0] exp_e;
  logic signed [SCORE_W:0] xdiff;
  logic div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;

  logic c_last, j_last, i_last;
  logic [CNT_W:0] bs_sum;
  logic [TOT_W+EXP_W-1:0] tot_prod;
  logic [TOT_W:0] tot_add;
  logic signed [WIDE_W-1:0] rs_prod, rs_sh;
  logic signed [ELEM_W+EXP_W:0] v_prod;
  logic signed [WIDE_W-1:0] ad_sum;
  logic [ACC_W:0] acc_ext, acc_mag;
  logic [ELEM_W-1:0] q_sat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && (in_opcode == OP_READ));
  assign cfg_ready = 1'b1;

  assign in_addr = {in_row, in_col};
  assign qi_addr = {i_r[ROW_W-1:0], c_r[COL_W-1:0]};
  assign kj_addr = {j_r[ROW_W-1:0], c_r[COL_W-1:0]};
  assign acc_raddr = (state_r == S_IDLE) ? in_addr : qi_addr;

  assign c_last = (c_r + 1'b1) == d_r;
  assign j_last = (j_r + 1'b1) == be_r;
  assign i_last = (i_r + 1'b1) == n_r;
  assign bs_sum = {1'b0, bs_r} + {1'b0, bl_r};

  assign xdiff = pass_r ? ({mn_r[SCORE_W-1], mn_r} - {score[SCORE_W-1], score})
                        : ({mn_r[SCORE_W-1], mn_r} - {mp_r[SCORE_W-1], mp_r});

  assign tot_prod = tot_r * r_r;
  assign tot_add  = {1'b0, tot_r} + {{(TOT_W+1-EXP_W){1'b0}}, e_nxt};
  assign rs_prod  = acc_rd * $signed({1'b0, r_r});
  assign rs_sh    = rs_prod >>> 16;
  assign v_prod   = $signed({1'b0, e_r}) * v_rd;
  assign ad_sum   = WIDE_W'(acc_rd) + WIDE_W'(v_prod >>> FRAC_W);
  assign acc_ext  = {acc_rd[ACC_W-1], acc_rd};
  assign acc_mag  = acc_rd[ACC_W-1] ? (~acc_ext + 1'b1) : acc_ext;
  assign div_num  = {acc_mag[ACC_W-1:0], {FRAC_W{1'b0}}};

  always_comb begin
    if (neg_r) begin
      q_sat = (div_quo > Q_MIN_MAG) ? 16'h8000 : (~div_quo[ELEM_W-1:0] + 1'b1);
    end else begin
      q_sat = (div_quo > Q_MAX) ? 16'h7fff : div_quo[ELEM_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    seq_len_nxt = seq_len_r;
    head_dim_nxt = head_dim_r;
    block_len_nxt = block_len_r;
    score_scale_nxt = score_scale_r;
    n_nxt = n_r; d_nxt = d_r; bl_nxt = bl_r; bs_nxt = bs_r; be_nxt = be_r;
    i_nxt = i_r; j_nxt = j_r; c_nxt = c_r;
    pass_nxt = pass_r; prev_nxt = prev_r; have_nxt = have_r; done_nxt = done_r;
    mp_nxt = mp_r; mn_nxt = mn_r; tot_nxt = tot_r; den_nxt = den_r;
    r_nxt = r_r; e_nxt = e_r; neg_nxt = neg_r;
    rd_row_nxt = rd_row_r; rd_col_nxt = rd_col_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r; out_row_nxt = out_row_r; out_col_nxt = out_col_r;
    mac_nxt = '0;
    q_we = 1'b0; k_we = 1'b0; v_we = 1'b0; acc_we = 1'b0; rm_we = 1'b0;
    acc_wdata = '0;
    div_start = 1'b0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SEQ_LEN:     seq_len_nxt = cfg_data[CNT_W-1:0];
        CFG_HEAD_DIM:    head_dim_nxt = cfg_data[CNT_W-1:0];
        CFG_BLOCK_LEN:   block_len_nxt = cfg_data[CNT_W-1:0];
        CFG_SCORE_SCALE: score_scale_nxt = cfg_data[SCALE_W-1:0];
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            OP_LOAD_Q:  q_we = 1'b1;
            OP_LOAD_K:  k_we = 1'b1;
            OP_LOAD_V:  v_we = 1'b1;
            OP_COMPUTE: state_nxt = S_INIT;
            OP_READ: begin
              rd_row_nxt = in_row;
              rd_col_nxt = in_col;
              state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_row_nxt = rd_row_r;
        out_col_nxt = rd_col_r;
        out_value_nxt = (done_r && ({1'b0, rd_row_r} < n_r) && ({1'b0, rd_col_r} < d_r))
                      ? acc_rd[ELEM_W-1:0] : '0;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        n_nxt = clamp_cfg(seq_len_r, MAX_ROWS);
        d_nxt = clamp_cfg(head_dim_r, MAX_DIM);
        bl_nxt = (block_len_r == '0) ? CNT_W'(1) : block_len_r;
        bs_nxt = '0;
        done_nxt = 1'b0;
        state_nxt = S_BLK;
      end
      S_BLK: begin
        be_nxt = (bs_sum >= {1'b0, n_r}) ? n_r : bs_sum[CNT_W-1:0];
        i_nxt = '0;
        prev_nxt = bs_r != '0;
        state_nxt = S_ROW0;
      end
      S_ROW0: state_nxt = S_ROW1;
      S_ROW1: begin
        mp_nxt = rmax_rd;
        mn_nxt = rmax_rd;
        have_nxt = prev_r;
        tot_nxt = prev_r ? rtot_rd : '0;
        j_nxt = bs_r;
        c_nxt = '0;
        pass_nxt = 1'b0;
        state_nxt = S_DOT;
      end
      S_DOT: begin
        mac_nxt.en = 1'b1;
        mac_nxt.first = c_r == '0;
        if (c_last) begin
          state_nxt = S_DOTW;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_DOTW: state_nxt = S_SC1;
      S_SC1:  state_nxt = S_SC2;
      S_SC2:  state_nxt = S_SCORE;
      S_SCORE: begin
        if (pass_r) begin
          state_nxt = S_X1;
        end else begin
          if (!have_r || score > mn_r) begin
            mn_nxt = score;
            have_nxt = 1'b1;
          end
          if (j_last) begin
            state_nxt = S_X1;
          end else begin
            j_nxt = j_r + 1'b1;
            c_nxt = '0;
            state_nxt = S_DOT;
          end
        end
      end
      S_X1: state_nxt = S_X2;
      S_X2: state_nxt = S_X3;
      S_X3: begin
        c_nxt = '0;
        if (pass_r) begin
          e_nxt = exp_e;
          tot_nxt = tot_add[TOT_W] ? {TOT_W{1'b1}} : tot_add[TOT_W-1:0];
          state_nxt = S_AD_RD;
        end else begin
          r_nxt = prev_r ? exp_e : '0;
          state_nxt = S_TOT;
        end
      end
      S_TOT: begin
        tot_nxt = tot_prod[TOT_W+15:16];
        state_nxt = prev_r ? S_RS_RD : S_RS_Z;
      end
      S_RS_Z, S_RS_WR: begin
        acc_we = 1'b1;
        acc_wdata = (state_r == S_RS_Z) ? '0 : sat_acc(rs_sh);
        if (c_last) begin
          pass_nxt = 1'b1;
          j_nxt = bs_r;
          c_nxt = '0;
          state_nxt = S_DOT;
        end else begin
          c_nxt = c_r + 1'b1;
          state_nxt = (state_r == S_RS_Z) ? S_RS_Z : S_RS_RD;
        end
      end
      S_RS_RD: state_nxt = S_RS_WR;
      S_AD_RD: state_nxt = S_AD_WR;
      S_AD_WR: begin
        acc_we = 1'b1;
        acc_wdata = sat_acc(ad_sum);
        if (c_last) begin
          if (j_last) begin
            state_nxt = S_ROWEND;
          end else begin
            j_nxt = j_r + 1'b1;
            c_nxt = '0;
            state_nxt = S_DOT;
          end
        end else begin
          c_nxt = c_r + 1'b1;
          state_nxt = S_AD_RD;
        end
      end
      S_ROWEND: begin
        rm_we = 1'b1;
        if (i_last) begin
          i_nxt = '0;
          if (bs_sum >= {1'b0, n_r}) begin
            state_nxt = S_FN_ROW;
          end else begin
            bs_nxt = bs_sum[CNT_W-1:0];
            state_nxt = S_BLK;
          end
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_ROW0;
        end
      end
      S_FN_ROW: state_nxt = S_FN_ROW1;
      S_FN_ROW1: begin
        den_nxt = rtot_rd;
        c_nxt = '0;
        state_nxt = S_FN_RD;
      end
      S_FN_RD: state_nxt = S_FN_ST;
      S_FN_ST, S_FN_WT: begin
        if (state_r == S_FN_ST && den_r != '0) begin
          neg_nxt = acc_rd[ACC_W-1];
          div_start = 1'b1;
          state_nxt = S_FN_WT;
        end else if (state_r == S_FN_ST || div_done) begin
          acc_we = 1'b1;
          acc_wdata = (state_r == S_FN_ST) ? '0 : {{(ACC_W-ELEM_W){q_sat[ELEM_W-1]}}, q_sat};
          if (c_last) begin
            if (i_last) begin
              done_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              i_nxt = i_r + 1'b1;
              state_nxt = S_FN_ROW;
            end
          end else begin
            c_nxt = c_r + 1'b1;
            state_nxt = S_FN_RD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seq_len_r <= CNT_W'(64);
      head_dim_r <= CNT_W'(64);
      block_len_r <= CNT_W'(16);
      score_scale_r <= SCALE_W'(8192);
      out_valid_r <= 1'b0;
      done_r <= 1'b0;
      mac_r <= '0;
    end else begin
      state_r <= state_nxt;
      seq_len_r <= seq_len_nxt;
      head_dim_r <= head_dim_nxt;
      block_len_r <= block_len_nxt;
      score_scale_r <= score_scale_nxt;
      out_valid_r <= out_valid_nxt;
      done_r <= done_nxt;
      mac_r <= mac_nxt;
      n_r <= n_nxt; d_r <= d_nxt; bl_r <= bl_nxt; bs_r <= bs_nxt; be_r <= be_nxt;
      i_r <= i_nxt; j_r <= j_nxt; c_r <= c_nxt;
      pass_r <= pass_nxt; prev_r <= prev_nxt; have_r <= have_nxt;
      mp_r <= mp_nxt; mn_r <= mn_nxt; tot_r <= tot_nxt; den_r <= den_nxt;
      r_r <= r_nxt; e_r <= e_nxt; neg_r <= neg_nxt;
      rd_row_r <= rd_row_nxt; rd_col_r <= rd_col_nxt;
      out_value_r <= out_value_nxt; out_row_r <= out_row_nxt; out_col_r <= out_col_nxt;
    end
  end

  tosa_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_qram (
    .clk(clk), .we(q_we), .waddr(in_addr), .wdata(in_value),
    .raddr(qi_addr), .rdata(q_rd)
  );

  tosa_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_kram (
    .clk(clk), .we(k_we), .waddr(in_addr), .wdata(in_value),
    .raddr(kj_addr), .rdata(k_rd)
  );

  tosa_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_vram (
    .clk(clk), .we(v_we), .waddr(in_addr), .wdata(in_value),
    .raddr(kj_addr), .rdata(v_rd)
  );

  tosa_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_accram (
    .clk(clk), .we(acc_we), .waddr(qi_addr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rd)
  );

  tosa_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_ROWS)) u_maxram (
    .clk(clk), .we(rm_we), .waddr(i_r[ROW_W-1:0]), .wdata(mn_r),
    .raddr(i_r[ROW_W-1:0]), .rdata(rmax_rd)
  );

  tosa_ram #(.WIDTH(TOT_W), .DEPTH(MAX_ROWS)) u_totram (
    .clk(clk), .we(rm_we), .waddr(i_r[ROW_W-1:0]), .wdata(tot_r),
    .raddr(i_r[ROW_W-1:0]), .rdata(rtot_rd)
  );

  tosa_score u_score (
    .clk(clk), .mac(mac_r), .q(q_rd), .k(k_rd), .scale(score_scale_r), .score(score)
  );

  tosa_exp u_exp (
    .clk(clk), .x(xdiff[EXPX_W-1:0]), .e(exp_e)
  );

  tosa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(den_r),
    .done(div_done), .quo(div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;

endmodule

/* hdl/tosa_check.sv */
// ----------------------------------------------------------------------------
// tosa_check
// Port-level checks of the tiled attention block, bound to the top level.
// ----------------------------------------------------------------------------
module tosa_check import tosa_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [2:0]               in_opcode,
  input logic [ROW_W-1:0]         in_row,
  input logic [COL_W-1:0]         in_col,
  input logic signed [ELEM_W-1:0] in_value,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [ELEM_W-1:0] out_value,
  input logic [ROW_W-1:0]         out_row,
  input logic [COL_W-1:0]         out_col,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [1:0]               cfg_index,
  input logic [15:0]              cfg_data
);

  logic rd_acc, cmp_acc;

  assign rd_acc  = in_valid && !in_stall && (in_opcode == OP_READ);
  assign cmp_acc = in_valid && !in_stall && (in_opcode == OP_COMPUTE);

  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc |=> in_stall)
    else $error("input not held during read");

  a_rd_word: assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc |=> ##1 (out_valid && out_row == $past(in_row, 2) && out_col == $past(in_col, 2)))
    else $error("read word missing or misaddressed");

  a_cmp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_acc |=> in_stall)
    else $error("input not held during compute");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_row)
                               && $stable(out_col))
    else $error("stalled output word changed");

endmodule

bind tiled_online_softmax_attention tosa_check u_tosa_check (.*);

/* tb/tb_attention_checker.sv */
// ----------------------------------------------------------------------------
// tb_attention_checker
// Watches the load/compute/read, result and register channels of the tiled
// attention block, keeps its own copy of the stores and registers, predicts
// every returned output element and compares it field by field.
// ----------------------------------------------------------------------------
module tb_attention_checker import tosa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [2:0]               in_opcode,
  input  logic [ROW_W-1:0]         in_row,
  input  logic [COL_W-1:0]         in_col,
  input  logic signed [ELEM_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [ELEM_W-1:0] out_value,
  input  logic [ROW_W-1:0]         out_row,
  input  logic [COL_W-1:0]         out_col,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  output int                       errors,
  output int                       pending,
  output int                       computes
);

  typedef struct {
    logic signed [ELEM_W-1:0] value;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
  } out_word_t;

  out_word_t expected_words[$];

  logic [CNT_W-1:0]   seq_len_q, head_dim_q, block_len_q;
  logic [SCALE_W-1:0] score_scale_q;
  logic signed [ELEM_W-1:0] q_mem [DEPTH];
  logic signed [ELEM_W-1:0] k_mem [DEPTH];
  logic signed [ELEM_W-1:0] v_mem [DEPTH];
  longint acc_mem [DEPTH];
  longint row_max [MAX_ROWS];
  bit     max_ok [MAX_ROWS];
  longint row_sum [MAX_ROWS];

  localparam int unsigned POW2 [17] = '{65536, 62757, 60097, 57549, 55109, 52773,
    50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint exp_neg_q16(longint x);
    longint y, ip, f, k, lo, t;
    if (x > (64'sd1 << 40)) return 0;
    y = (x * 23637) >>> 14;
    ip = y >>> 12;
    if (ip > 16) return 0;
    f = y & 4095;
    k = f >>> 8;
    lo = f & 255;
    t = POW2[k] - (((POW2[k] - POW2[k+1]) * lo) >>> 8);
    return t >>> ip;
  endfunction

  function automatic longint scaled_score(int i, int j, int d);
    longint dot;
    dot = 0;
    for (int c = 0; c < d; c++)
      dot += longint'(q_mem[i*MAX_DIM+c]) * longint'(k_mem[j*MAX_DIM+c]);
    return sat32((dot * longint'(score_scale_q)) >>> 28);
  endfunction

  task automatic run_attention();
    int n, d, bl, be;
    longint mp, mn, r, tot, s, e, q;
    bit have;
    n = (seq_len_q < 1) ? 1 : (seq_len_q > MAX_ROWS) ? MAX_ROWS : seq_len_q;
    d = (head_dim_q < 1) ? 1 : (head_dim_q > MAX_DIM) ? MAX_DIM : head_dim_q;
    bl = (block_len_q < 1) ? 1 : block_len_q;
    for (int a = 0; a < DEPTH; a++) acc_mem[a] = 0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      row_max[i] = 0;
      max_ok[i] = 0;
      row_sum[i] = 0;
    end
    for (int bs = 0; bs < n; bs += bl) begin
      be = (n - bs > bl) ? bs + bl : n;
      for (int i = 0; i < n; i++) begin
        mp = row_max[i];
        mn = mp;
        have = max_ok[i];
        for (int j = bs; j < be; j++) begin
          s = scaled_score(i, j, d);
          if (!have || s > mn) begin
            mn = s;
            have = 1;
          end
        end
        r = max_ok[i] ? exp_neg_q16(mn - mp) : 0;
        for (int c = 0; c < d; c++)
          acc_mem[i*MAX_DIM+c] = sat32((acc_mem[i*MAX_DIM+c] * r) >>> 16);
        tot = (row_sum[i] * r) >>> 16;
        for (int j = bs; j < be; j++) begin
          s = scaled_score(i, j, d);
          e = exp_neg_q16(mn - s);
          tot += e;
          if (tot > 64'sd4294967295) tot = 64'sd4294967295;
          for (int c = 0; c < d; c++)
            acc_mem[i*MAX_DIM+c] = sat32(acc_mem[i*MAX_DIM+c] +
                                         ((e * longint'(v_mem[j*MAX_DIM+c])) >>> 12));
        end
        row_sum[i] = tot;
        row_max[i] = mn;
        max_ok[i] = 1;
      end
    end
    for (int i = 0; i < n; i++)
      for (int c = 0; c < d; c++) begin
        q = 0;
        if (row_sum[i] != 0) q = (acc_mem[i*MAX_DIM+c] * 4096) / row_sum[i];
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        acc_mem[i*MAX_DIM+c] = q;
      end
  endtask

  assign pending = expected_words.size();

  always @(posedge clk) begin
    int idx;
    out_word_t w, x;
    if (!rst_n) begin
      seq_len_q <= 7'd64;
      head_dim_q <= 7'd64;
      block_len_q <= 7'd16;
      score_scale_q <= 16'd8192;
      for (int a = 0; a < DEPTH; a++) begin
        q_mem[a] = '0;
        k_mem[a] = '0;
        v_mem[a] = '0;
        acc_mem[a] = 0;
      end
      expected_words.delete();
      errors <= 0;
      computes <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEQ_LEN:     seq_len_q <= cfg_data[CNT_W-1:0];
          CFG_HEAD_DIM:    head_dim_q <= cfg_data[CNT_W-1:0];
          CFG_BLOCK_LEN:   block_len_q <= cfg_data[CNT_W-1:0];
          CFG_SCORE_SCALE: score_scale_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        idx = in_row * MAX_DIM + in_col;
        case (in_opcode)
          OP_LOAD_Q:  q_mem[idx] = in_value;
          OP_LOAD_K:  k_mem[idx] = in_value;
          OP_LOAD_V:  v_mem[idx] = in_value;
          OP_COMPUTE: begin
            run_attention();
            computes <= computes + 1;
          end
          OP_READ: begin
            w.value = acc_mem[idx][ELEM_W-1:0];
            w.row = in_row;
            w.col = in_col;
            expected_words.push_back(w);
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: value %0d row %0d col %0d", out_value, out_row, out_col);
          errors <= errors + 1;
        end else begin
          x = expected_words.pop_front();
          if (out_value !== x.value || out_row !== x.row || out_col !== x.col)
            errors <= errors + 1;
          if (out_value !== x.value)
            $error("out_value: expected %0d, got %0d", x.value, out_value);
          if (out_row !== x.row)
            $error("out_row: expected %0d, got %0d", x.row, out_row);
          if (out_col !== x.col)
            $error("out_col: expected %0d, got %0d", x.col, out_col);
        end
      end
    end
  end

endmodule

/* tb/tb_tiled_online_softmax_attention.sv */
// ----------------------------------------------------------------------------
// tb_tiled_online_softmax_attention
// Stimulus for the tiled attention block: directed extremes, then random
// phases of register setup, store fills, computes and reads under bursty
// input and a stalling receiver. The checker beside the block scores it.
// ----------------------------------------------------------------------------
module tb_tiled_online_softmax_attention;
  import tosa_pkg::*;

  localparam int NUM_ITEMS = 1350;
  localparam int LIMIT     = 6000000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               in_opcode;
  logic [ROW_W-1:0]         in_row;
  logic [COL_W-1:0]         in_col;
  logic signed [ELEM_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [ELEM_W-1:0] out_value;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         out_col;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [15:0]              cfg_data;

  int errors, pending, computes;
  int cycles;
  int items_sent;
  int burst_left;
  int stall_left;
  int stall_mode;
  bit q_seen [DEPTH];
  bit k_seen [DEPTH];
  bit v_seen [DEPTH];

  tiled_online_softmax_attention u_top (.*);

  tb_attention_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 0);
      2:       out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send_word(logic [2:0] op, int row, int col, int val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_row <= row[ROW_W-1:0];
    in_col <= col[COL_W-1:0];
    in_value <= val[ELEM_W-1:0];
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (op <= OP_READ) items_sent++;
    case (op)
      OP_LOAD_Q: q_seen[row*MAX_DIM+col] = 1;
      OP_LOAD_K: k_seen[row*MAX_DIM+col] = 1;
      OP_LOAD_V: v_seen[row*MAX_DIM+col] = 1;
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[15:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(int n, int d, int b, int s);
    write_reg(CFG_SEQ_LEN, n | ($urandom_range(0, 511) << 7));
    write_reg(CFG_HEAD_DIM, d | ($urandom_range(0, 511) << 7));
    write_reg(CFG_BLOCK_LEN, b | ($urandom_range(0, 511) << 7));
    write_reg(CFG_SCORE_SCALE, s);
  endtask

  function automatic int rand_elem();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 8191) - 4096;
  endfunction

  task automatic noise_word(int n, int d);
    case ($urandom_range(0, 4))
      0: send_word($urandom_range(5, 7), $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 65535));
      1: send_word($urandom_range(0, 2), $urandom_range(0, 63), $urandom_range(0, 63),
                   rand_elem());
      default: send_word(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 65535));
    endcase
  endtask

  initial begin
    int n, d, b, s, nc, dc, pick, reads, ent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_row = '0;
    in_col = '0;
    in_value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_stall = 1'b0;
    cycles = 0;
    items_sent = 0;
    burst_left = 0;
    stall_left = 0;
    stall_mode = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: read before any compute, extremes of data and scale
    send_word(OP_READ, 0, 0, 0);
    send_word(OP_READ, 63, 63, 32'hffff);
    drain();
    set_regs(2, 2, 1, 16'hffff);
    send_word(OP_LOAD_Q, 0, 0, 32767);
    send_word(OP_LOAD_Q, 0, 1, -32768);
    send_word(OP_LOAD_Q, 1, 0, 0);
    send_word(OP_LOAD_Q, 1, 1, 1);
    send_word(OP_LOAD_K, 0, 0, -32768);
    send_word(OP_LOAD_K, 0, 1, 32767);
    send_word(OP_LOAD_K, 1, 0, 32767);
    send_word(OP_LOAD_K, 1, 1, -1);
    send_word(OP_LOAD_V, 0, 0, 32767);
    send_word(OP_LOAD_V, 0, 1, -32768);
    send_word(OP_LOAD_V, 1, 0, -32768);
    send_word(OP_LOAD_V, 1, 1, 32767);
    send_word(OP_COMPUTE, 0, 0, 0);
    send_word(3'd5, 1, 1, 0);
    send_word(3'd6, 0, 1, 0);
    send_word(3'd7, 63, 63, 32'hffff);
    send_word(OP_READ, 0, 0, 0);
    send_word(OP_READ, 0, 1, 0);
    send_word(OP_READ, 1, 0, 0);
    send_word(OP_READ, 1, 1, 0);
    send_word(OP_READ, 63, 63, 0);
    drain();

    // random phases
    while (items_sent < NUM_ITEMS) begin
      pick = $urandom_range(0, 19);
      n = $urandom_range(1, 8);
      d = $urandom_range(1, 8);
      b = $urandom_range(0, 9);
      s = $urandom_range(0, 65535);
      case (pick)
        0: begin n = 64; d = $urandom_range(1, 2); b = $urandom_range(8, 64); end
        1: begin n = 127; d = 1; b = 127; end
        2: begin n = $urandom_range(1, 2); d = 64; b = $urandom_range(0, 1); end
        3: begin n = 0; d = 127; b = 0; end
        4: begin n = $urandom_range(0, 1); d = 0; s = 0; end
        5: s = 65535;
        6: b = 64;
        default: ;
      endcase
      set_regs(n, d, b, s);
      nc = (n < 1) ? 1 : (n > 64) ? 64 : n;
      dc = (d < 1) ? 1 : (d > 64) ? 64 : d;
      for (int i = 0; i < nc; i++)
        for (int c = 0; c < dc; c++) begin
          ent = i * MAX_DIM + c;
          if (!q_seen[ent] || $urandom_range(0, 2) == 0) send_word(OP_LOAD_Q, i, c, rand_elem());
          if (!k_seen[ent] || $urandom_range(0, 2) == 0) send_word(OP_LOAD_K, i, c, rand_elem());
          if (!v_seen[ent] || $urandom_range(0, 2) == 0) send_word(OP_LOAD_V, i, c, rand_elem());
          if ($urandom_range(0, 9) == 0) noise_word(nc, dc);
        end
      send_word(OP_COMPUTE, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 65535));
      if ($urandom_range(0, 5) == 0)
        send_word(OP_COMPUTE, 0, 0, 0);
      reads = $urandom_range(8, 24);
      for (int r = 0; r < reads; r++) begin
        if ($urandom_range(0, 4) == 0)
          noise_word(nc, dc);
        else
          send_word(OP_READ, $urandom_range(0, nc - 1), $urandom_range(0, dc - 1),
                    $urandom_range(0, 65535));
      end
      drain();
    end

    $display("Ran %0d words over %0d computes with register settings from one to full size.",
             items_sent, computes);
    $display("Outputs were read under bursty input and a stalling receiver.");
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tosa_pkg.sv
hdl/tosa_ram.sv
hdl/tosa_score.sv
hdl/tosa_exp.sv
hdl/tosa_div.sv
hdl/tiled_online_softmax_attention.sv
hdl/tosa_check.sv
tb/tb_attention_checker.sv
tb/tb_tiled_online_softmax_attention.sv
